/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle, disabled during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ssh_pkg.sv */
// ---------------------------------------------------------------------------
// ssh_pkg
// Types and constants of the shared stack and heap memory.
// ---------------------------------------------------------------------------
package ssh_pkg;

  // Operation codes carried on the request side.
  typedef enum logic [2:0] {
    MODE_LOAD  = 3'd0,
    MODE_STORE = 3'd1,
    MODE_PUSH  = 3'd2,
    MODE_POP   = 3'd3,
    MODE_ALLOC = 3'd4
  } mode_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_RANGE       = 3'd1,
    ST_STACK_OVF   = 3'd2,
    ST_STACK_EMPTY = 3'd3,
    ST_HEAP_OVF    = 3'd4
  } status_t;

  // Register map.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned HB_W    = 6;
  localparam logic [HB_W-1:0] HEAP_BASE_RESET = 6'd7;
  localparam logic REG_HEAP_BASE = 1'b0;

  // Configuration update from the register block.
  typedef struct packed {
    logic            wr;
    logic [HB_W-1:0] heap_base;
  } cfg_t;

endpackage

/* hdl/ssh_ram.sv */
// ---------------------------------------------------------------------------
// ssh_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module ssh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ssh_cfg.sv */
// ---------------------------------------------------------------------------
// ssh_cfg
// APB register block holding the heap base register.
// ---------------------------------------------------------------------------
module ssh_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssh_pkg::PADDR_W-1:0] paddr,
  input  logic [ssh_pkg::DATA_W-1:0]  pwdata,
  output logic [ssh_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ssh_pkg::cfg_t               cfg
);
  import ssh_pkg::*;

  logic [HB_W-1:0] heap_base;
  logic            wr_hit;

  assign pready = 1'b1;

  // Register index is the word address; only index zero exists.
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_HEAP_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= HEAP_BASE_RESET;
    end else if (wr_hit) begin
      heap_base <= pwdata[HB_W-1:0];
    end
  end

  // Read back, zero for addresses beyond the register list.
  assign prdata = (paddr[2] == REG_HEAP_BASE) ? {{(DATA_W-HB_W){1'b0}}, heap_base}
                                              : '0;

  // The heap pointer follows a write in the same cycle.
  assign cfg.wr        = wr_hit;
  assign cfg.heap_base = pwdata[HB_W-1:0];

endmodule

/* hdl/shared_stack_heap_memory.sv */
// Flow: the accepted request and its memory read are registered, then the result register is loaded.
// Interlock: a new request is held off while one is in flight, until the read-modify-write
// of the one in flight has reached the RAM, and while the result register is stalled.
// Reset: pointers return to an empty stack and the heap base, then a clearing pass
// writes zero to all DEPTH words, one per cycle, before the first request is taken.
// ---------------------------------------------------------------------------
// shared_stack_heap_memory
// Word memory shared by an upward heap and a downward stack, with load, store,
// push, pop and heap allocation requests and status reporting.
// ---------------------------------------------------------------------------
module shared_stack_heap_memory #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssh_pkg::PADDR_W-1:0] paddr,
  input  logic [ssh_pkg::DATA_W-1:0]  pwdata,
  output logic [ssh_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // Request stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,  // address[31:0], data[63:32]
  input  logic [2:0]                  s_tuser,  // mode[2:0]
  // Result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [47:0]                 m_tdata   // read_data[31:0], alloc_address[37:32],
                                                // status[40:38], zero fill[47:41]
);
  import ssh_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW:0]   DEPTH_SP = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  cfg_t cfg;

  // Control state
  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic [AW:0]   sp, sp_next;
  logic [AW-1:0] hp, hp_next;
  logic          pend;
  logic          pend_wr;
  logic          pend_rd;

  // Payload of the request in flight
  logic [AW-1:0]   pend_waddr;
  logic [31:0]     pend_wdata;
  logic [5:0]      pend_alloc;
  status_t         pend_status;

  // Decode of the accepted request
  logic          acc;
  mode_t         mode;
  logic [31:0]   req_addr;
  logic [31:0]   req_data;
  logic          addr_ok;
  logic [AW:0]   hp_inc;
  logic [AW:0]   sp_dec;
  status_t       st;
  logic          wr;
  logic          rd;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [5:0]    alloc;
  logic [AW-1:0] base_clamped;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  ssh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Heap base loads the heap pointer, clamped to the top word.
  assign base_clamped = (32'(cfg.heap_base) >= 32'(DEPTH)) ? LAST_ADDR
                                                           : AW'(cfg.heap_base);

  // One request at a time, only after the clearing pass and when the result register is free.
  assign s_tready = !clearing && !pend && (!m_tvalid || m_tready);
  assign acc      = s_tvalid && s_tready;
  assign mode     = mode_t'(s_tuser);
  assign req_addr = s_tdata[31:0];
  assign req_data = s_tdata[63:32];
  assign addr_ok  = req_addr < 32'(DEPTH);
  assign hp_inc   = {1'b0, hp} + 1'b1;
  assign sp_dec   = sp - 1'b1;

  // Request decode: checks, pointer moves and the memory access to make.
  always_comb begin
    st      = ST_OK;
    wr      = 1'b0;
    rd      = 1'b0;
    waddr   = '0;
    wdata   = req_data;
    raddr   = '0;
    alloc   = '0;
    sp_next = sp;
    hp_next = hp;
    case (mode)
      MODE_LOAD: begin
        if (!addr_ok) begin
          st = ST_RANGE;
        end else begin
          rd    = 1'b1;
          raddr = req_addr[AW-1:0];
        end
      end
      MODE_STORE: begin
        if (!addr_ok) begin
          st = ST_RANGE;
        end else begin
          wr    = 1'b1;
          waddr = req_addr[AW-1:0];
        end
      end
      MODE_PUSH: begin
        if (sp <= hp_inc) begin
          st = ST_STACK_OVF;
        end else begin
          sp_next = sp_dec;
          wr      = 1'b1;
          waddr   = sp_dec[AW-1:0];
        end
      end
      MODE_POP: begin
        if (sp >= DEPTH_SP) begin
          st = ST_STACK_EMPTY;
        end else begin
          rd      = 1'b1;
          raddr   = sp[AW-1:0];
          wr      = 1'b1;
          waddr   = sp[AW-1:0];
          wdata   = '0;
          sp_next = sp + 1'b1;
        end
      end
      MODE_ALLOC: begin
        if (hp_inc >= sp) begin
          st = ST_HEAP_OVF;
        end else begin
          hp_next = hp_inc[AW-1:0];
          wr      = 1'b1;
          waddr   = hp_inc[AW-1:0];
          alloc   = 6'(hp_inc[AW-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers: clearing sweep, pointers, request in flight, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      sp       <= DEPTH_SP;
      hp       <= AW'(HEAP_BASE_RESET);
      pend     <= 1'b0;
      pend_wr  <= 1'b0;
      pend_rd  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
      end
      if (cfg.wr) begin
        hp <= base_clamped;
      end else if (acc) begin
        hp <= hp_next;
      end
      if (acc) begin
        sp <= sp_next;
      end
      pend    <= acc;
      pend_wr <= acc && wr;
      pend_rd <= acc && rd;
      if (pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload of the request in flight.
  always_ff @(posedge clk) begin
    if (acc) begin
      pend_waddr  <= waddr;
      pend_wdata  <= wdata;
      pend_alloc  <= alloc;
      pend_status <= st;
    end
  end

  // Result register, loaded once the read data is back.
  always_ff @(posedge clk) begin
    if (pend) begin
      m_tdata <= {7'd0, pend_status, pend_alloc, pend_rd ? ram_rdata : 32'd0};
    end
  end

  // Write port: the clearing sweep, otherwise the write of the request in flight.
  assign ram_we    = clearing || pend_wr;
  assign ram_waddr = clearing ? clr_addr : pend_waddr;
  assign ram_wdata = clearing ? 32'd0 : pend_wdata;

  ssh_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

endmodule

/* hdl/ssh_checker.sv */
// ---------------------------------------------------------------------------
// ssh_checker
// Port-level checks of the shared stack and heap memory, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // A stalled result holds its value.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // Only one request is worked on at a time.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "request taken while another is in flight")

  // Status codes stay within the defined set.
  `ASSERT_NOW(a_status_code, clk, rst, m_tvalid, m_tdata[40:38] <= 3'd4, "undefined status code")

  // A failed request returns no data and no heap address.
  `ASSERT_NOW(a_error_clean, clk, rst, m_tvalid && (m_tdata[40:38] != 3'd0), m_tdata[37:0] == 38'd0, "error result carries data")

endmodule

bind shared_stack_heap_memory ssh_checker u_ssh_checker (.*);
